>>> src/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants and types for the running median core.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int HEAP_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int COUNT_BITS      = 12;

    typedef struct packed {
        logic push;
        logic replace;
    } heap_cmd_t;

endpackage

>>> src/rmth_heap.sv
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap in a synchronous memory: push with sift-up, replace-top
// with sift-down, moving a hole one level per read/compare pair.
// ----------------------------------------------------------------------------
module rmth_heap #(
    parameter int DEPTH = rmth_pkg::HEAP_DEPTH_DEF,
    parameter int W     = rmth_pkg::SAMPLE_BITS_DEF,
    parameter bit IS_MAX = 1'b1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmth_pkg::heap_cmd_t               cmd,
    input  logic signed [W-1:0]               value,
    output logic                              busy,
    output logic signed [W-1:0]               top,
    output logic [$clog2(DEPTH+1)-1:0]        count
);
    import rmth_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UP_RD  = 5'b00010,
        ST_UP_CMP = 5'b00100,
        ST_DN_RD  = 5'b01000,
        ST_DN_CMP = 5'b10000
    } heap_state_t;

    function automatic logic goes_first(input logic signed [W-1:0] a,
                                        input logic signed [W-1:0] b);
        if (IS_MAX)
            return a > b;
        else
            return a < b;
    endfunction

    logic signed [W-1:0] heap_mem [DEPTH];

    heap_state_t         state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic signed [W-1:0] val_reg, val_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [W-1:0] top_reg;
    logic signed [W-1:0] rd_a_reg, rd_b_reg;

    logic                we;
    logic [AW-1:0]       waddr, raddr_a, raddr_b, parent;
    logic signed [W-1:0] wdata, best_val;
    logic [XW-1:0]       left, right, cnt_x;
    logic                sel_l, sel_r;

    assign parent   = AW'((idx_reg - AW'(1)) >> 1);
    assign left     = (XW'(idx_reg) << 1) | XW'(1);
    assign right    = left + XW'(1);
    assign cnt_x    = XW'(count_reg);
    assign sel_l    = (left < cnt_x) && goes_first(rd_a_reg, val_reg);
    assign best_val = sel_l ? rd_a_reg : val_reg;
    assign sel_r    = (right < cnt_x) && goes_first(rd_b_reg, best_val);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        raddr_a    = parent;
        raddr_b    = right[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.push)
                begin
                    idx_next   = AW'(count_reg);
                    val_next   = value;
                    count_next = count_reg + CW'(1);
                    state_next = ST_UP_RD;
                end
                else if (cmd.replace)
                begin
                    idx_next   = '0;
                    val_next   = value;
                    state_next = ST_DN_RD;
                end
            end
            ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                we = 1'b1;
                if (goes_first(val_reg, rd_a_reg))
                begin
                    wdata      = rd_a_reg;
                    idx_next   = parent;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DN_RD:
            begin
                raddr_a = left[AW-1:0];
                if (left >= cnt_x)
                begin
                    we         = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP:
            begin
                we = 1'b1;
                if (sel_r)
                begin
                    wdata      = rd_b_reg;
                    idx_next   = right[AW-1:0];
                    state_next = ST_DN_RD;
                end
                else if (sel_l)
                begin
                    wdata      = rd_a_reg;
                    idx_next   = left[AW-1:0];
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        if (we && waddr == '0)
            top_reg <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[waddr] <= wdata;
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    assign busy  = (state_reg != ST_IDLE);
    assign top   = top_reg;
    assign count = count_reg;

endmodule

>>> src/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Running median over a stream of signed samples using a max-heap for the
// lower half and a min-heap for the upper half, each in its own memory.
// ----------------------------------------------------------------------------
// One item in, one result out. The core takes no new item until it is
// through with the last one: every heap level walked takes a memory read
// state and a compare/write state, and the insert into one heap runs
// alongside the top replacement in the other. A new item is accepted while
// the previous result still waits on the output. median_doubled is
// twice the median; once both heaps are full further samples come back with
// dropped set and the previous median. No clearing pass is needed after reset.
module running_median_two_heaps_core #(
    parameter int HEAP_DEPTH  = rmth_pkg::HEAP_DEPTH_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [SAMPLE_BITS:0]         median_doubled,
    output logic [rmth_pkg::COUNT_BITS-1:0]     sample_count,
    output logic                                dropped
);
    import rmth_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } ctl_state_t;

    ctl_state_t          state_reg, state_next;
    logic signed [W-1:0] sample_reg;
    logic                drop_reg, drop_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [W:0]   median_reg;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic                dropped_out_reg;

    heap_cmd_t           lo_cmd, up_cmd;
    logic signed [W-1:0] lo_val, up_val, lo_top, up_top;
    logic                lo_busy, up_busy;
    logic [CW-1:0]       lo_cnt, up_cnt;
    logic [CW:0]         total;
    logic                full, load;
    logic signed [W:0]   lo_x, up_x, median;

    rmth_heap #(.DEPTH(HEAP_DEPTH), .W(W), .IS_MAX(1'b1)) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lo_cmd),
        .value (lo_val),
        .busy  (lo_busy),
        .top   (lo_top),
        .count (lo_cnt)
    );

    rmth_heap #(.DEPTH(HEAP_DEPTH), .W(W), .IS_MAX(1'b0)) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (up_cmd),
        .value (up_val),
        .busy  (up_busy),
        .top   (up_top),
        .count (up_cnt)
    );

    assign total  = (CW + 1)'(lo_cnt) + (CW + 1)'(up_cnt);
    assign full   = total >= (CW + 1)'(2 * HEAP_DEPTH);
    assign lo_x   = {lo_top[W-1], lo_top};
    assign up_x   = {up_top[W-1], up_top};
    assign median = lo_x + ((lo_cnt == up_cnt) ? up_x : lo_x);
    assign load   = (state_reg == ST_FINISH) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next     = state_reg;
        drop_next      = drop_reg;
        lo_cmd         = '0;
        up_cmd         = '0;
        lo_val         = sample_reg;
        up_val         = sample_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && result_stall);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                drop_next  = full;
                state_next = full ? ST_FINISH : ST_WAIT;
                if (!full)
                begin
                    if (lo_cnt <= up_cnt)
                    begin
                        lo_cmd.push = 1'b1;
                        if (lo_cnt != '0 && up_cnt != '0 && sample_reg > lo_top
                            && sample_reg > up_top)
                        begin
                            up_cmd.replace = 1'b1;
                            lo_val         = up_top;
                        end
                    end
                    else
                    begin
                        up_cmd.push = 1'b1;
                        if (sample_reg <= lo_top)
                        begin
                            lo_cmd.replace = 1'b1;
                            up_val         = lo_top;
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (!lo_busy && !up_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
        if (state_reg == ST_IDLE)
            sample_reg <= sample;
        if (load)
        begin
            median_reg      <= median;
            count_out_reg   <= COUNT_BITS'(total);
            dropped_out_reg <= drop_reg;
        end
    end

    assign sample_stall   = (state_reg != ST_IDLE);
    assign result_valid   = out_valid_reg;
    assign median_doubled = median_reg;
    assign sample_count   = count_out_reg;
    assign dropped        = dropped_out_reg;

endmodule

>>> src/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks for the running median core, bound to the top level.
// ----------------------------------------------------------------------------
module rmth_checker #(
    parameter int HEAP_DEPTH  = rmth_pkg::HEAP_DEPTH_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    input  logic                                sample_stall,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic signed [SAMPLE_BITS:0]         median_doubled,
    input  logic [rmth_pkg::COUNT_BITS-1:0]     sample_count,
    input  logic                                dropped
);
    import rmth_pkg::*;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(2 * HEAP_DEPTH);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("input taken again right after an item");

    a_drop_at_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && dropped) |-> (sample_count == FULL_COUNT))
        else $error("dropped item while storage not full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
        (result_valid && $stable(median_doubled) && $stable(sample_count)
         && $stable(dropped)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_stall) |=> sample_valid)
        else $error("input valid dropped while stalled");

endmodule

bind running_median_two_heaps_core rmth_checker #(
    .HEAP_DEPTH  (HEAP_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rmth_checker (.*);

>>> tb/running_median_two_heaps_core_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core_tb
// Streams signed samples through the running median core with random idling
// on both sides. A two-heap model predicts the doubled median, the sample
// count and the drop flag. The stream runs past full storage so that
// dropped samples are exercised.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core_tb;

    localparam int DEPTH = rmth_pkg::HEAP_DEPTH_DEF;
    localparam int SBITS = rmth_pkg::SAMPLE_BITS_DEF;
    localparam int CBITS = rmth_pkg::COUNT_BITS;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic signed [SBITS:0] med;
        logic [CBITS-1:0]      cnt;
        logic                  drop;
    } median_t;

    logic                    clk;
    logic                    rst_n;
    logic                    sample_valid;
    logic                    sample_stall;
    logic signed [SBITS-1:0] sample;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [SBITS:0]   median_doubled;
    logic [CBITS-1:0]        sample_count;
    logic                    dropped;

    running_median_two_heaps_core uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall),
        .median_doubled(median_doubled), .sample_count(sample_count), .dropped(dropped)
    );

    logic signed [SBITS-1:0] pending_samples[$];
    median_t                 expected_medians[$];
    longint                  low_heap[DEPTH];
    longint                  high_heap[DEPTH];
    int                      low_n;
    int                      high_n;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    bit                      hold_send;
    bit                      in_taken;
    bit                      failed;
    int                      cycles;

    function automatic bit ahead(longint a, longint b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(ref longint h[DEPTH], ref int n, input longint v,
                             input bit is_max);
        int     i;
        int     p;
        longint t;
        if (n >= DEPTH)
            return;
        h[n] = v;
        i = n;
        n++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ahead(h[i], h[p], is_max))
                break;
            t = h[i]; h[i] = h[p]; h[p] = t;
            i = p;
        end
    endtask

    task automatic heap_swap_top(ref longint h[DEPTH], input int n, input longint v,
                                 input bit is_max, output longint old);
        int     i;
        int     l;
        int     best;
        longint t;
        old = h[0];
        h[0] = v;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            best = i;
            if (l < n && ahead(h[l], h[best], is_max))
                best = l;
            if (l + 1 < n && ahead(h[l + 1], h[best], is_max))
                best = l + 1;
            if (best == i)
                break;
            t = h[i]; h[i] = h[best]; h[best] = t;
            i = best;
        end
    endtask

    task automatic predict_median(input logic signed [SBITS-1:0] smp);
        longint  s;
        longint  v;
        longint  m;
        median_t e;
        s = smp;
        e.drop = 1'b0;
        if (low_n + high_n >= 2 * DEPTH)
            e.drop = 1'b1;
        else if (low_n <= high_n)
        begin
            if (low_n == 0 || high_n == 0 || s <= low_heap[0])
                heap_push(low_heap, low_n, s, 1'b1);
            else if (s > high_heap[0])
            begin
                heap_swap_top(high_heap, high_n, s, 1'b0, v);
                heap_push(low_heap, low_n, v, 1'b1);
            end
            else
                heap_push(low_heap, low_n, s, 1'b1);
        end
        else if (s <= low_heap[0])
        begin
            heap_swap_top(low_heap, low_n, s, 1'b1, v);
            heap_push(high_heap, high_n, v, 1'b0);
        end
        else
            heap_push(high_heap, high_n, s, 1'b0);
        m = 0;
        if (low_n > 0)
            m = (low_n == high_n) ? low_heap[0] + high_heap[0] : 2 * low_heap[0];
        e.med = m[SBITS:0];
        e.cnt = CBITS'(low_n + high_n);
        expected_medians.push_back(e);
    endtask

    always #4 clk = ~clk;

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || in_taken))
        begin
            if (pending_samples.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                sample_valid <= 1'b1;
                sample <= pending_samples[0];
                predict_median(pending_samples.pop_front());
            end
            else
                sample_valid <= 1'b0;
        end
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken <= rst_n && sample_valid && !sample_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_medians.size() == 0)
            begin
                $display("%0t: unexpected result median=%0d count=%0d dropped=%0b",
                         $time, median_doubled, sample_count, dropped);
                failed <= 1'b1;
            end
            else
            begin
                if (median_doubled !== expected_medians[0].med)
                begin
                    $display("%0t: median_doubled expected %0d actual %0d", $time,
                             expected_medians[0].med, median_doubled);
                    failed <= 1'b1;
                end
                if (sample_count !== expected_medians[0].cnt)
                begin
                    $display("%0t: sample_count expected %0d actual %0d", $time,
                             expected_medians[0].cnt, sample_count);
                    failed <= 1'b1;
                end
                if (dropped !== expected_medians[0].drop)
                begin
                    $display("%0t: dropped expected %0b actual %0b", $time,
                             expected_medians[0].drop, dropped);
                    failed <= 1'b1;
                end
                void'(expected_medians.pop_front());
            end
        end
        if (cycles > LIMIT)
        begin
            $display("** running_median_two_heaps_core: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || sample_valid || expected_medians.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [SBITS-1:0] r;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        in_taken = 1'b0;
        failed = 1'b0;
        cycles = 0;
        low_n = 0;
        high_n = 0;
        hold_send = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 83;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;

        // extremes, ties, both rebalance directions
        pending_samples = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                            0, -1, 1, 5, 5, 5, -7, 100, 100, -100, 3, 3, 32'sh55555555,
                            32'shaaaaaaaa, 2, -2};
        wait_drained();
        hold_send = 1'b1;
        repeat (20) @(posedge clk);
        hold_send = 1'b0;

        // fill to capacity and beyond, in three idling phases
        for (int i = 0; i < 1880; i++)
        begin
            case ($urandom_range(3))
                0: r = $urandom;
                1: r = $urandom_range(20) - 10;
                2: r = $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                         : 32'sh80000000 + $urandom_range(3);
                default: r = $urandom_range(1000);
            endcase
            pending_samples.push_back(r);
            if (i == 620 || i == 1250)
            begin
                wait_drained();
                if (i == 620)
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 10;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            end
        end
        for (int i = 0; i < 160; i++)
            pending_samples.push_back($urandom);
        wait_drained();
        repeat (100) @(posedge clk);
        if (!failed)
            $display("** running_median_two_heaps_core: PASSED **");
        else
            $display("** running_median_two_heaps_core: FAILED **");
        $finish;
    end

endmodule

>>> running_median_two_heaps_core.f
src/rmth_pkg.sv
src/rmth_heap.sv
src/running_median_two_heaps_core.sv
src/rmth_checker.sv
tb/running_median_two_heaps_core_tb.sv
